>>> hw/rtl/awao_pkg.sv
// Shared constants, types and helper functions for the accel window average block.
package awao_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SAMPLE_W   = 8;
  localparam int ENTRY_W    = 3 * SAMPLE_W;
  localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int AVG_W      = 10;
  localparam int OUT_W      = 9;
  localparam int OFS_W      = 8;
  localparam int AVG_MAX    = 128;

  // Window thresholds on the sample period in milliseconds
  localparam int PERIOD_WIN2 = 200;
  localparam int PERIOD_WIN4 = 100;
  localparam int PERIOD_WIN8 = 40;
  localparam int WIN_MAX     = 16;

  // Offset scaling: (64 * pct) / 100 == (16 * pct) / 25, reciprocal of 25 in Q16
  localparam int OFS_RECIP = 2622;
  localparam int OFS_SHIFT = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] PERIOD_RST = 16'd60;
  localparam logic [2:0]  ORIENT_RST = 3'd7;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_ORIENT   = 3'd1,
    REG_PORTRAIT = 3'd2,
    REG_OFS_X    = 3'd3,
    REG_OFS_Y    = 3'd4,
    REG_OFS_Z    = 3'd5
  } cfg_reg_t;

  // Averaging window from the sample period, saturated at the ring depth
  function automatic logic [CNT_W-1:0] window_limit(input logic [15:0] period);
    int lim;
    if (int'(period) >= PERIOD_WIN2) begin
      lim = 2;
    end else if (int'(period) >= PERIOD_WIN4) begin
      lim = 4;
    end else if (int'(period) >= PERIOD_WIN8) begin
      lim = 8;
    end else begin
      lim = WIN_MAX;
    end
    if (lim > RING_DEPTH) begin
      lim = RING_DEPTH;
    end
    return CNT_W'(lim);
  endfunction

  // Source axis of an output axis: odd rotation codes exchange x and y
  function automatic logic [1:0] remap_src(input logic [2:0] code, input logic [1:0] axis);
    logic [1:0] src;
    if (axis == 2'd2) begin
      src = 2'd2;
    end else if (code[0]) begin
      src = (axis == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      src = axis;
    end
    return src;
  endfunction

  // Negate mask per rotation code, bit a belongs to output axis a
  function automatic logic [2:0] remap_neg(input logic [2:0] code);
    logic [2:0] neg;
    unique case (code)
      3'd0:    neg = 3'b000;
      3'd1:    neg = 3'b010;
      3'd2:    neg = 3'b011;
      3'd3:    neg = 3'b001;
      3'd4:    neg = 3'b101;
      3'd5:    neg = 3'b111;
      3'd6:    neg = 3'b110;
      3'd7:    neg = 3'b100;
      default: neg = 3'b000;
    endcase
    return neg;
  endfunction

  // Offset counts from a signed percent, truncated toward zero
  function automatic logic signed [OFS_W-1:0] pct_to_offset(input logic [7:0] pct);
    logic [8:0]  mag;
    logic [11:0] scaled;
    logic [23:0] prod;
    logic [7:0]  quo;
    mag    = pct[7] ? (9'd256 - {1'b0, pct}) : {1'b0, pct};
    scaled = {mag[7:0], 4'b0000};
    prod   = 24'(scaled) * 24'(OFS_RECIP);
    quo    = prod[OFS_SHIFT +: 8];
    return pct[7] ? $signed(8'd0 - quo) : $signed(quo);
  endfunction

endpackage

>>> hw/rtl/awao_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awao_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/accel_window_average_orient_unit.sv
// Accelerometer window average with axis remap and per-axis offset: top level.
//
// Usage: a sample request (in_raw_x/y/z, signed bytes) is taken on in_valid & in_ready.
// It is written into a 16-entry sample RAM, entries 0 to fill-1 are read back one per
// cycle and summed per axis, the three sums are divided by the fill count in a
// restoring divider per axis (one quotient bit per cycle), and the averages
// are remapped by the orientation code, optionally swapped to portrait and offset.
// One result request leaves on out_valid & out_ready for every sample.
// Between accept and out_valid lie the RAM read sweep, the divider and the output load.
// One sample is in flight at a time; in_ready rises again the cycle after the result
// is loaded into the output register, so the next sample can be taken while that
// result still waits for the receiver.
// A stalled receiver holds the output register; a finished item then waits for it.
// Configuration writes (cfg_valid, cfg_index, cfg_wdata) are always taken at once and
// are to be issued only while the block is idle. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) clears the write position, the fill count and the
// per-entry valid bits, so every ring entry reads as zero until written; no sweep.
module accel_window_average_orient_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_raw_x,
  input  logic [7:0]             in_raw_y,
  input  logic [7:0]             in_raw_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [8:0]      out_accel_x,
  output logic signed [8:0]      out_accel_y,
  output logic signed [8:0]      out_accel_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [15:0]                           period_r;
  logic [2:0]                            orient_r;
  logic                                  portrait_r;
  logic signed [awao_pkg::OFS_W-1:0]     ofs_r [3];

  // Ring control
  logic [awao_pkg::CNT_W-1:0]            wp_r;
  logic [awao_pkg::CNT_W-1:0]            fill_r;
  logic [awao_pkg::RING_DEPTH-1:0]       vld_r;
  logic [awao_pkg::CNT_W-1:0]            rd_idx_r;
  logic                                  pend_r;
  logic                                  rd_vld_r;
  logic [awao_pkg::STEP_W-1:0]           div_step_r;
  logic                                  out_valid_r;

  // Datapath registers
  logic signed [awao_pkg::SUM_W-1:0]     acc_r [3];
  logic [awao_pkg::SUM_W-1:0]            div_dvd_r [3];
  logic [awao_pkg::CNT_W-1:0]            div_rem_r [3];
  logic                                  div_neg_r [3];
  logic signed [awao_pkg::OUT_W-1:0]     out_r [3];

  logic [awao_pkg::CNT_W-1:0]            lim;
  logic [awao_pkg::CNT_W-1:0]            wp_eff;
  logic [awao_pkg::CNT_W-1:0]            wp_nxt;
  logic [awao_pkg::CNT_W:0]              fill_inc;
  logic [awao_pkg::CNT_W-1:0]            fill_nxt;
  logic                                  accept;
  logic                                  rd_go;
  logic                                  sum_done;
  logic                                  div_done;
  logic                                  out_load;
  logic [awao_pkg::IDX_W-1:0]            waddr;
  logic [awao_pkg::IDX_W-1:0]            raddr;
  logic [awao_pkg::ENTRY_W-1:0]          ram_rdata;
  logic [awao_pkg::ENTRY_W-1:0]          rd_entry;
  logic [awao_pkg::SUM_W-1:0]            div_dvd_nxt [3];
  logic [awao_pkg::CNT_W-1:0]            div_rem_nxt [3];
  logic signed [awao_pkg::AVG_W-1:0]     avg [3];
  logic signed [awao_pkg::AVG_W-1:0]     rot [3];
  logic signed [awao_pkg::AVG_W-1:0]     fin [3];
  logic signed [awao_pkg::AVG_W-1:0]     res [3];
  logic [2:0]                            neg_mask;

  // Handshake
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_accel_x = out_r[0];
  assign out_accel_y = out_r[1];
  assign out_accel_z = out_r[2];

  // Window limit, write position and fill count update
  assign lim      = awao_pkg::window_limit(period_r);
  assign wp_eff   = (wp_r >= lim) ? '0 : wp_r;
  assign wp_nxt   = wp_eff + 1'b1;
  assign fill_inc = {1'b0, fill_r} + 1'b1;
  assign fill_nxt = (fill_inc >= {1'b0, lim}) ? lim : fill_inc[awao_pkg::CNT_W-1:0];
  assign waddr    = wp_eff[awao_pkg::IDX_W-1:0];

  // Read sweep over entries 0 to fill-1
  assign rd_go    = (state_r == ST_SUM) && (rd_idx_r != fill_r);
  assign raddr    = rd_idx_r[awao_pkg::IDX_W-1:0];
  assign sum_done = (state_r == ST_SUM) && !rd_go && !pend_r;
  assign div_done = (state_r == ST_DIV) &&
                    (div_step_r == awao_pkg::STEP_W'(awao_pkg::SUM_W - 1));
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign rd_entry = rd_vld_r ? ram_rdata : '0;

  awao_ram #(
    .WIDTH (awao_pkg::ENTRY_W),
    .DEPTH (awao_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata ({in_raw_z, in_raw_y, in_raw_x}),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= awao_pkg::PERIOD_RST;
      orient_r   <= awao_pkg::ORIENT_RST;
      portrait_r <= 1'b0;
      ofs_r[0]   <= '0;
      ofs_r[1]   <= '0;
      ofs_r[2]   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        awao_pkg::REG_PERIOD:   period_r   <= cfg_wdata;
        awao_pkg::REG_ORIENT:   orient_r   <= cfg_wdata[2:0];
        awao_pkg::REG_PORTRAIT: portrait_r <= cfg_wdata[0];
        awao_pkg::REG_OFS_X:    ofs_r[0]   <= awao_pkg::pct_to_offset(cfg_wdata[7:0]);
        awao_pkg::REG_OFS_Y:    ofs_r[1]   <= awao_pkg::pct_to_offset(cfg_wdata[7:0]);
        awao_pkg::REG_OFS_Z:    ofs_r[2]   <= awao_pkg::pct_to_offset(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

  // Sequencer and ring control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      vld_r       <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      div_step_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the receiver takes the old one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            wp_r         <= wp_nxt;
            fill_r       <= fill_nxt;
            vld_r[waddr] <= 1'b1;
            rd_idx_r     <= '0;
            pend_r       <= 1'b0;
            state_r      <= ST_SUM;
          end
        end
        ST_SUM: begin
          pend_r   <= rd_go;
          rd_vld_r <= vld_r[raddr];
          if (rd_go) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (sum_done) begin
            div_step_r <= '0;
            state_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_step_r <= div_step_r + 1'b1;
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // One restoring division step per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [awao_pkg::CNT_W:0] trial;
      logic                     fits;
      trial = {div_rem_r[a], div_dvd_r[a][awao_pkg::SUM_W-1]};
      fits  = (trial >= {1'b0, fill_r});
      div_rem_nxt[a] = fits ? awao_pkg::CNT_W'(trial - {1'b0, fill_r})
                            : trial[awao_pkg::CNT_W-1:0];
      div_dvd_nxt[a] = {div_dvd_r[a][awao_pkg::SUM_W-2:0], fits};
    end
  end

  // Accumulate, divide and hold the result
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (accept) begin
        acc_r[a] <= '0;
      end else if (state_r == ST_SUM && pend_r) begin
        acc_r[a] <= acc_r[a] + awao_pkg::SUM_W'($signed(rd_entry[a*awao_pkg::SAMPLE_W +:
                                                               awao_pkg::SAMPLE_W]));
      end
      if (sum_done) begin
        div_neg_r[a] <= acc_r[a][awao_pkg::SUM_W-1];
        div_dvd_r[a] <= acc_r[a][awao_pkg::SUM_W-1] ? awao_pkg::SUM_W'(-acc_r[a])
                                                    : awao_pkg::SUM_W'(acc_r[a]);
        div_rem_r[a] <= '0;
      end else if (state_r == ST_DIV) begin
        div_dvd_r[a] <= div_dvd_nxt[a];
        div_rem_r[a] <= div_rem_nxt[a];
      end
      if (out_load) begin
        out_r[a] <= res[a][awao_pkg::OUT_W-1:0];
      end
    end
  end

  // Signed averages, rotation remap, portrait swap and offset
  always_comb begin
    neg_mask = awao_pkg::remap_neg(orient_r);
    for (int a = 0; a < 3; a++) begin
      logic [awao_pkg::AVG_W-1:0] mag;
      mag    = awao_pkg::AVG_W'(div_dvd_r[a]);
      avg[a] = div_neg_r[a] ? $signed(-mag) : $signed(mag);
    end
    for (int a = 0; a < 3; a++) begin
      logic signed [awao_pkg::AVG_W-1:0] v;
      v      = avg[awao_pkg::remap_src(orient_r, 2'(a))];
      rot[a] = neg_mask[a] ? -v : v;
    end
    if (!portrait_r) begin
      fin[0] = rot[1];
      fin[1] = -rot[0];
      fin[2] = rot[2];
    end else begin
      fin[0] = rot[0];
      fin[1] = rot[1];
      fin[2] = rot[2];
    end
    for (int a = 0; a < 3; a++) begin
      res[a] = fin[a] + awao_pkg::AVG_W'(ofs_r[a]);
    end
  end

  // Write position never runs past the ring
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= awao_pkg::CNT_W'(awao_pkg::RING_DEPTH))
    else $error("write position beyond ring depth");

  // A sample in flight always has a nonzero divisor
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM || state_r == ST_DIV) |-> (fill_r != '0))
    else $error("fill count zero while averaging");

  // Read data is expected only during the sweep
  a_pend_sum: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SUM))
    else $error("read pending outside the sum sweep");

  // Averages stay within a signed byte magnitude
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |->
      (div_dvd_r[0] <= awao_pkg::SUM_W'(awao_pkg::AVG_MAX)) &&
      (div_dvd_r[1] <= awao_pkg::SUM_W'(awao_pkg::AVG_MAX)) &&
      (div_dvd_r[2] <= awao_pkg::SUM_W'(awao_pkg::AVG_MAX)))
    else $error("average magnitude out of range");

  // Only one sample is taken at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second sample accepted while busy");

endmodule

>>> bench/testbench.sv
// Testbench for the accel window average orient unit: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module testbench;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 7;
  localparam int          TOTAL_SAMPLES = 1650;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          LONG_HOLD     = 400;
  localparam int          CYCLE_LIMIT   = 1000000;

  // Register indexes the block does not decode
  localparam logic [2:0]  CFG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;

  // Negate flags per output axis, bit n belongs to orientation code n
  localparam logic [7:0]  FLIP_X        = 8'b0011_1100;
  localparam logic [7:0]  FLIP_Y        = 8'b0110_0110;
  localparam logic [7:0]  FLIP_Z        = 8'b1111_0000;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [8:0] z;
  } accel_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  // Predict averaged, remapped results and match them against the block
  class accel_scoreboard;
    logic signed [7:0] ring [awao_pkg::RING_DEPTH][3];
    int unsigned       wr_pos;
    int unsigned       fill;
    logic [15:0]       period;
    logic [2:0]        orient;
    logic              portrait_native;
    logic signed [7:0] ofs_pct [3];
    accel_t            awaiting [$];
    int                errors;

    function new();
      foreach (ring[i, a]) ring[i][a] = '0;
      wr_pos          = 0;
      fill            = 0;
      period          = awao_pkg::PERIOD_RST;
      orient          = awao_pkg::ORIENT_RST;
      portrait_native = 1'b0;
      foreach (ofs_pct[a]) ofs_pct[a] = '0;
      errors          = 0;
    endfunction

    function int unsigned window_size();
      int unsigned w;
      if (period >= 16'd200) begin
        w = 2;
      end else if (period >= 16'd100) begin
        w = 4;
      end else if (period >= 16'd40) begin
        w = 8;
      end else begin
        w = 16;
      end
      if (w > awao_pkg::RING_DEPTH) begin
        w = awao_pkg::RING_DEPTH;
      end
      return w;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        awao_pkg::REG_PERIOD:   period = data;
        awao_pkg::REG_ORIENT:   orient = data[2:0];
        awao_pkg::REG_PORTRAIT: portrait_native = data[0];
        awao_pkg::REG_OFS_X:    ofs_pct[0] = data[7:0];
        awao_pkg::REG_OFS_Y:    ofs_pct[1] = data[7:0];
        awao_pkg::REG_OFS_Z:    ofs_pct[2] = data[7:0];
        default: ;
      endcase
    endfunction

    // Store the sample, average the window and queue the expected result
    function void note_sample(logic [7:0] rx, logic [7:0] ry, logic [7:0] rz);
      int unsigned lim;
      int unsigned i;
      int          a;
      int          sum;
      int          avg [3];
      int          rot [3];
      int          fin [3];
      int          res [3];
      logic [7:0]  raw [3];
      accel_t      want;
      raw[0] = rx;
      raw[1] = ry;
      raw[2] = rz;
      lim = window_size();
      // wrap the write position when the window shrank under it
      if (wr_pos >= lim) begin
        wr_pos = 0;
      end
      for (a = 0; a < 3; a++) begin
        ring[wr_pos][a] = raw[a];
      end
      wr_pos++;
      fill++;
      if (fill >= lim) begin
        fill = lim;
      end
      for (a = 0; a < 3; a++) begin
        sum = 0;
        for (i = 0; i < fill; i++) begin
          sum += ring[i][a];
        end
        avg[a] = sum / int'(fill);
      end
      // odd codes exchange x and y, then negate per axis
      rot[0] = orient[0] ? avg[1] : avg[0];
      rot[1] = orient[0] ? avg[0] : avg[1];
      rot[2] = avg[2];
      if (FLIP_X[orient]) rot[0] = -rot[0];
      if (FLIP_Y[orient]) rot[1] = -rot[1];
      if (FLIP_Z[orient]) rot[2] = -rot[2];
      if (!portrait_native) begin
        fin[0] = rot[1];
        fin[1] = -rot[0];
        fin[2] = rot[2];
      end else begin
        fin = rot;
      end
      for (a = 0; a < 3; a++) begin
        res[a] = fin[a] + (64 * int'(ofs_pct[a])) / 100;
      end
      want.x = 9'(res[0]);
      want.y = 9'(res[1]);
      want.z = 9'(res[2]);
      awaiting.push_back(want);
    endfunction

    function void check_result(accel_t got);
      accel_t want;
      if (awaiting.size() == 0) begin
        $display("%0t: result with none expected: x=%0d y=%0d z=%0d",
                 $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: accel_x expected %0d, got %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: accel_y expected %0d, got %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: accel_z expected %0d, got %0d", $time, want.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  in_raw_x    = '0;
  logic [7:0]  in_raw_y    = '0;
  logic [7:0]  in_raw_z    = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic signed [8:0] out_accel_x;
  logic signed [8:0] out_accel_y;
  logic signed [8:0] out_accel_z;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_wdata   = '0;

  accel_scoreboard sb;
  rx_mode_t        stall_mode  = RX_ALWAYS;
  bit              gaps_on     = 1'b0;
  int unsigned     hold_tokens = 0;
  int unsigned     hold_seen   = 0;
  int unsigned     hold_left   = 0;
  int unsigned     rx_cycle    = 0;
  int unsigned     cycle_count = 0;
  int unsigned     samples_sent = 0;
  accel_t          rx_result;

  accel_window_average_orient_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .in_raw_z    (in_raw_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_accel_x (out_accel_x),
    .out_accel_y (out_accel_y),
    .out_accel_z (out_accel_z),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Check each result request, then pick the next ready value
  always @(posedge clk) begin
    rx_cycle++;
    if (rst_n && out_valid && out_ready) begin
      rx_result.x = out_accel_x;
      rx_result.y = out_accel_y;
      rx_result.z = out_accel_z;
      sb.check_result(rx_result);
    end
    if (hold_tokens != hold_seen) begin
      hold_seen = hold_tokens;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
        RX_PATTERN: out_ready <= ((rx_cycle % 11) < 6);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       b = 8'h00;
        1:       b = 8'h7F;
        2:       b = 8'h80;
        default: b = 8'hFF;
      endcase
    end else begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  function automatic logic [15:0] pick_period();
    logic [15:0] p;
    case ($urandom_range(0, 9))
      0:       p = 16'd0;
      1:       p = 16'd39;
      2:       p = 16'd40;
      3:       p = 16'd99;
      4:       p = 16'd100;
      5:       p = 16'd199;
      6:       p = 16'd200;
      7:       p = 16'hFFFF;
      default: p = 16'($urandom_range(0, 260));
    endcase
    return p;
  endfunction

  // Mostly in range, with the extremes and any byte now and then
  function automatic logic [15:0] pick_pct();
    logic [7:0] p;
    case ($urandom_range(0, 7))
      0:       p = 8'd100;
      1:       p = 8'h9C;
      2:       p = 8'($urandom);
      default: p = 8'($urandom_range(0, 200) - 100);
    endcase
    return {8'($urandom), p};
  endfunction

  // Offer one sample request and hold it until accepted; valid stays high
  task automatic send_sample(logic [7:0] x, logic [7:0] y, logic [7:0] z);
    in_valid <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, y, z);
    samples_sent++;
  endtask

  // Offer one register write request; valid stays high
  task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Drop the input and wait until every expected result has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random samples, in bursts with gaps between them when gaps are on
  task automatic send_random(int unsigned count);
    int unsigned n;
    int unsigned burst_left;
    burst_left = $urandom_range(1, 12);
    for (n = 0; n < count; n++) begin
      send_sample(pick_byte(), pick_byte(), pick_byte());
      if (gaps_on && n + 1 < count) begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  task automatic randomize_config();
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_PERIOD, pick_period());
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_ORIENT, 16'($urandom));
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_PORTRAIT, 16'($urandom));
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_OFS_X, pick_pct());
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_OFS_Y, pick_pct());
    if ($urandom_range(0, 1)) write_cfg(awao_pkg::REG_OFS_Z, pick_pct());
    if ($urandom_range(0, 7) == 0) begin
      write_cfg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    end
  endtask

  initial begin
    int          c;
    int unsigned phase;
    int unsigned count;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: window of 8, extreme bytes
    send_sample(8'h80, 8'h80, 8'h80);
    send_sample(8'h7F, 8'h7F, 8'h7F);
    send_sample(8'h00, 8'hFF, 8'h01);
    send_sample(8'h80, 8'h7F, 8'h80);
    send_sample(8'hFF, 8'hFF, 8'hFF);
    send_sample(8'h80, 8'h80, 8'h80);
    send_sample(8'h80, 8'h80, 8'h80);
    send_sample(8'h80, 8'h80, 8'h80);
    settle();

    // Widen to 16, offsets at +100, -100 and an out-of-range byte; spare indexes
    write_cfg(awao_pkg::REG_PERIOD, 16'd0);
    write_cfg(awao_pkg::REG_OFS_X, 16'hA564);
    write_cfg(awao_pkg::REG_OFS_Y, 16'h009C);
    write_cfg(awao_pkg::REG_OFS_Z, 16'hFF80);
    write_cfg(CFG_SPARE_LO, 16'hFFFF);
    write_cfg(CFG_SPARE_HI, 16'h0000);
    cfg_valid <= 1'b0;
    stall_mode = RX_RANDOM;
    send_sample(8'h7F, 8'h80, 8'h7F);
    send_sample(8'h7F, 8'h80, 8'h7F);
    send_sample(8'h7F, 8'h80, 8'h7F);
    send_sample(8'h80, 8'h7F, 8'h80);
    send_sample(8'h80, 8'h7F, 8'h80);
    send_sample(8'h80, 8'h7F, 8'h80);
    settle();

    // Shrink to 2 with the write position far above it, then every orientation
    write_cfg(awao_pkg::REG_PERIOD, 16'hFFFF);
    write_cfg(awao_pkg::REG_OFS_Z, 16'h007F);
    for (c = 0; c < 8; c++) begin
      write_cfg(awao_pkg::REG_ORIENT, {13'($urandom), 3'(c)});
      write_cfg(awao_pkg::REG_PORTRAIT, {15'($urandom), c[1]});
      cfg_valid <= 1'b0;
      send_sample(pick_byte(), pick_byte(), pick_byte());
      settle();
    end

    // Random phases, each with its own settings and idling
    phase = 0;
    while (samples_sent < TOTAL_SAMPLES) begin
      randomize_config();
      cfg_valid <= 1'b0;
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      gaps_on    = ($urandom_range(0, 3) != 0);
      if (phase == 1 || phase % 9 == 5) begin
        hold_tokens++;
      end
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(3, 40);
      send_random(count);
      settle();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/awao_pkg.sv
hw/rtl/awao_ram.sv
hw/rtl/accel_window_average_orient_unit.sv
bench/testbench.sv
